/* rtl/hid_response_deframer_top_assert.svh */
// ----------------------------------------------------------------------------
// hid response deframer assertion macros
// concurrent assertion forms used by the deframer back module
// ----------------------------------------------------------------------------
`ifndef HID_RESPONSE_DEFRAMER_TOP_ASSERT_SVH
`define HID_RESPONSE_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define HRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hrd_pkg.sv */
// ----------------------------------------------------------------------------
// hrd_pkg
// types and constants shared by the hid response deframer modules
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int REPORT_BYTES_DEF = 65;
  localparam int STORE_DEPTH      = 64;
  localparam int STORE_AW         = $clog2(STORE_DEPTH);
  localparam int CAPACITY_LIMIT   = 56;
  localparam int CMDQ_DEPTH       = 2;

  localparam logic [7:0] REPORT_ID   = 8'h00;
  localparam logic [7:0] FRAME_TYPE  = 8'h02;
  localparam logic [7:0] END_MARKER  = 8'hFD;
  localparam logic [7:0] DIR_BYTE    = 8'hD5;
  localparam logic [7:0] CHK_INVERT  = 8'hFF;
  localparam logic [7:0] MIN_LEN     = 8'd6;
  localparam logic [7:0] HDR_TRAILER = 8'd8;

  typedef enum logic [0:0] {
    CFG_LAST_CMD    = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_ID       = 4'd1,
    ST_TYPE     = 4'd2,
    ST_LEN      = 4'd3,
    ST_CHECKSUM = 4'd4,
    ST_END      = 4'd5,
    ST_DIR      = 4'd6,
    ST_CMD      = 4'd7,
    ST_SIZE     = 4'd8
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } back_state_t;

endpackage

/* rtl/hrd_ram.sv */
// ----------------------------------------------------------------------------
// hrd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module hrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hrd_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/hrd_cmd_queue.sv */
// ----------------------------------------------------------------------------
// hrd_cmd_queue
// two-entry fifo of frame outcomes between the front and back parts
// ----------------------------------------------------------------------------
module hrd_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hrd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output hrd_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int PW = $clog2(hrd_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(hrd_pkg::CMDQ_DEPTH + 1);

  hrd_pkg::cmd_t entry_r [hrd_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(hrd_pkg::CMDQ_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(hrd_pkg::CMDQ_DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(hrd_pkg::CMDQ_DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/hrd_front.sv */
// ----------------------------------------------------------------------------
// hrd_front
// accepts report bytes, runs the frame checks and buffers payload bytes
// ----------------------------------------------------------------------------
module hrd_front #(
  parameter int REPORT_BYTES = hrd_pkg::REPORT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [7:0]                   in_rx_byte,
  input  logic                         in_report_start,
  output logic                         in_stall,
  input  logic [7:0]                   last_cmd,
  input  logic [5:0]                   max_payload,
  input  logic                         q_full,
  input  logic                         store_busy,
  output logic                         push,
  output hrd_pkg::cmd_t                push_cmd,
  output logic                         wr_en,
  output logic [hrd_pkg::STORE_AW-1:0] wr_addr,
  output logic [7:0]                   wr_data
);

  localparam int PW = $clog2(REPORT_BYTES);

  logic [PW-1:0]    pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  hrd_pkg::status_t ferr_r, ferr_nxt;
  logic             done_r, done_nxt;

  logic             in_fire, act, will_write;
  logic [PW-1:0]    p;
  logic [8:0]       p9, len9, widx;
  logic [7:0]       sum_b, cmd_exp;
  logic [5:0]       cap;
  hrd_pkg::status_t ferr_b, t, end_st;

  assign len9       = {1'b0, len_r};
  assign will_write = ~done_r & (pos_r >= PW'(7)) & (9'(pos_r) + 9'd2 <= len9);
  assign in_stall   = q_full | (store_busy & will_write);
  assign in_fire    = in_valid & ~in_stall;
  assign cap        = (max_payload > 6'(hrd_pkg::CAPACITY_LIMIT)) ?
                      6'(hrd_pkg::CAPACITY_LIMIT) : max_payload;
  assign cmd_exp    = 8'(last_cmd + 8'd1);

  always_comb begin
    act      = in_fire & (in_report_start | ~done_r);
    p        = in_report_start ? '0 : pos_r;
    p9       = 9'(p);
    widx     = 9'(p9 - 9'd7);
    sum_b    = in_report_start ? 8'd0 : sum_r;
    ferr_b   = in_report_start ? hrd_pkg::ST_OK : ferr_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    ferr_nxt = ferr_r;
    done_nxt = done_r;
    push     = 1'b0;
    push_cmd = '{status: hrd_pkg::ST_OK, count: 6'd0};
    wr_en    = 1'b0;
    wr_addr  = widx[hrd_pkg::STORE_AW-1:0];
    wr_data  = in_rx_byte;

    t = ferr_b;
    if (p9 == 9'd5 && in_rx_byte != hrd_pkg::DIR_BYTE && t == hrd_pkg::ST_OK) begin
      t = hrd_pkg::ST_DIR;
    end
    if (p9 == 9'd6 && in_rx_byte != cmd_exp && t == hrd_pkg::ST_OK) begin
      t = hrd_pkg::ST_CMD;
    end

    if (t == hrd_pkg::ST_CHECKSUM) begin
      end_st = hrd_pkg::ST_CHECKSUM;
    end else if (in_rx_byte != hrd_pkg::END_MARKER) begin
      end_st = hrd_pkg::ST_END;
    end else if (t != hrd_pkg::ST_OK) begin
      end_st = t;
    end else if (len_r < hrd_pkg::HDR_TRAILER ||
                 8'(len_r - hrd_pkg::HDR_TRAILER) > {2'b00, cap}) begin
      end_st = hrd_pkg::ST_SIZE;
    end else begin
      end_st = hrd_pkg::ST_OK;
    end

    if (act) begin
      pos_nxt  = PW'(p + 1'b1);
      sum_nxt  = sum_b;
      ferr_nxt = ferr_b;
      done_nxt = 1'b0;
      if (p9 == 9'd0) begin
        if (in_rx_byte != hrd_pkg::REPORT_ID) begin
          push     = 1'b1;
          push_cmd = '{status: hrd_pkg::ST_ID, count: 6'd0};
          done_nxt = 1'b1;
        end
      end else if (p9 == 9'd1) begin
        sum_nxt = 8'(sum_b + in_rx_byte);
        if (in_rx_byte != hrd_pkg::FRAME_TYPE) begin
          push     = 1'b1;
          push_cmd = '{status: hrd_pkg::ST_TYPE, count: 6'd0};
          done_nxt = 1'b1;
        end
      end else if (p9 == 9'd2) begin
        sum_nxt = 8'(sum_b + in_rx_byte);
        len_nxt = in_rx_byte;
        if (in_rx_byte < hrd_pkg::MIN_LEN || {1'b0, in_rx_byte} >= 9'(REPORT_BYTES)) begin
          push     = 1'b1;
          push_cmd = '{status: hrd_pkg::ST_LEN, count: 6'd0};
          done_nxt = 1'b1;
        end
      end else if (p9 + 9'd2 <= len9) begin
        sum_nxt  = 8'(sum_b + in_rx_byte);
        ferr_nxt = t;
        wr_en    = (p9 >= 9'd7) && (widx < 9'(hrd_pkg::STORE_DEPTH));
      end else if (p9 + 9'd1 == len9) begin
        ferr_nxt = ((sum_b ^ hrd_pkg::CHK_INVERT) != in_rx_byte) ? hrd_pkg::ST_CHECKSUM : t;
      end else begin
        ferr_nxt = t;
        done_nxt = 1'b1;
        push     = 1'b1;
        push_cmd.status = end_st;
        push_cmd.count  = (end_st == hrd_pkg::ST_OK) ?
                          6'(len_r - hrd_pkg::HDR_TRAILER) : 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      ferr_r <= hrd_pkg::ST_OK;
      done_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      ferr_r <= ferr_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

/* rtl/hrd_back.sv */
// ----------------------------------------------------------------------------
// hrd_back
// turns queued frame outcomes into status results or payload runs
// ----------------------------------------------------------------------------
module hrd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  hrd_pkg::cmd_t                q_head,
  output logic                         q_pop,
  output logic                         busy,
  output logic                         rd_en,
  output logic [hrd_pkg::STORE_AW-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_has_byte,
  output logic                         out_last,
  output logic [3:0]                   out_status,
  output logic [5:0]                   out_payload_count
);

  `include "hid_response_deframer_top_assert.svh"

  hrd_pkg::back_state_t state_r, state_nxt;
  logic [5:0]           idx_r, idx_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 has_r, has_nxt;
  logic                 last_r, last_nxt;
  hrd_pkg::status_t     status_r, status_nxt;
  logic [5:0]           ocnt_r, ocnt_nxt;
  logic                 out_free, load;

  assign out_free = ~out_valid_r | ~out_stall;
  assign busy     = (state_r != hrd_pkg::BK_IDLE);
  assign rd_addr  = idx_r[hrd_pkg::STORE_AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    byte_nxt   = byte_r;
    has_nxt    = has_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    ocnt_nxt   = ocnt_r;
    case (state_r)
      hrd_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.status != hrd_pkg::ST_OK || q_head.count == 6'd0) begin
            load       = 1'b1;
            byte_nxt   = 8'd0;
            has_nxt    = 1'b0;
            last_nxt   = 1'b1;
            status_nxt = q_head.status;
            ocnt_nxt   = 6'd0;
          end else begin
            idx_nxt   = 6'd0;
            cnt_nxt   = q_head.count;
            state_nxt = hrd_pkg::BK_FETCH;
          end
        end
      end
      hrd_pkg::BK_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = hrd_pkg::BK_SEND;
      end
      hrd_pkg::BK_SEND: begin
        if (out_free) begin
          load       = 1'b1;
          byte_nxt   = rd_data;
          has_nxt    = 1'b1;
          last_nxt   = (6'(idx_r + 1'b1) == cnt_r);
          status_nxt = hrd_pkg::ST_OK;
          ocnt_nxt   = cnt_r;
          if (6'(idx_r + 1'b1) == cnt_r) begin
            state_nxt = hrd_pkg::BK_IDLE;
          end else begin
            idx_nxt   = 6'(idx_r + 1'b1);
            state_nxt = hrd_pkg::BK_FETCH;
          end
        end
      end
      default: begin
        state_nxt = hrd_pkg::BK_IDLE;
      end
    endcase
    out_valid_nxt = load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    byte_r   <= byte_nxt;
    has_r    <= has_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = byte_r;
  assign out_has_byte      = has_r;
  assign out_last          = last_r;
  assign out_status        = status_r;
  assign out_payload_count = ocnt_r;

  `HRD_ASSERT_NOW(a_data_only_ok, clk, rst_n, out_valid_r && has_r,
    status_r == hrd_pkg::ST_OK && ocnt_r != 6'd0, "payload result with bad status")
  `HRD_ASSERT_NOW(a_err_single, clk, rst_n, out_valid_r && status_r != hrd_pkg::ST_OK,
    last_r && !has_r && ocnt_r == 6'd0, "status result not a single final result")
  `HRD_ASSERT_NOW(a_idx_range, clk, rst_n, state_r == hrd_pkg::BK_SEND,
    idx_r < cnt_r, "playback index past payload count")
  `HRD_ASSERT_NEXT(a_fetch_send, clk, rst_n, state_r == hrd_pkg::BK_FETCH,
    state_r == hrd_pkg::BK_SEND, "fetch not followed by send")

endmodule

/* rtl/hid_response_deframer_top.sv */
// ----------------------------------------------------------------------------
// hid_response_deframer_top
// checks fixed-size hid response reports and plays out their payload
// ----------------------------------------------------------------------------
// Report bytes are taken one per cycle unless the input stalls. The front
// checks id, type, length, checksum, end marker, direction, response code and
// payload size and writes payload bytes into a 64-entry payload ram; each
// frame outcome goes into a two-entry queue. The back plays a good payload out
// one byte at a time, through a ram read and then the output register, or
// gives a single status result. Input stalls while the outcome queue is full,
// and while a payload byte is due but the back is busy or the queue not empty.
module hid_response_deframer_top #(
  parameter int REPORT_BYTES = hrd_pkg::REPORT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_report_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic       out_last,
  output logic [3:0] out_status,
  output logic [5:0] out_payload_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0]                   last_cmd_r;
  logic [5:0]                   max_payload_r;
  logic                         q_full, q_empty, q_pop, push, back_busy;
  hrd_pkg::cmd_t                push_cmd, q_head;
  logic                         wr_en, rd_en;
  logic [hrd_pkg::STORE_AW-1:0] wr_addr, rd_addr;
  logic [7:0]                   wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_r    <= 8'd0;
      max_payload_r <= 6'(hrd_pkg::CAPACITY_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrd_pkg::CFG_LAST_CMD:    last_cmd_r    <= cfg_data;
        hrd_pkg::CFG_MAX_PAYLOAD: max_payload_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  hrd_front #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_rx_byte      (in_rx_byte),
    .in_report_start (in_report_start),
    .in_stall        (in_stall),
    .last_cmd        (last_cmd_r),
    .max_payload     (max_payload_r),
    .q_full          (q_full),
    .store_busy      (back_busy | ~q_empty),
    .push            (push),
    .push_cmd        (push_cmd),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

  hrd_ram #(
    .WIDTH(8),
    .DEPTH(hrd_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hrd_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  hrd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .busy              (back_busy),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_has_byte      (out_has_byte),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_payload_count (out_payload_count)
  );

endmodule

/* tb/hid_response_deframer_checker.sv */
// ----------------------------------------------------------------------------
// hid_response_deframer_checker
// watches the report, result and register channels of the deframer, predicts
// every result from the accepted report bytes and compares field by field
// ----------------------------------------------------------------------------
module hid_response_deframer_checker #(
  parameter int REPORT_BYTES = hrd_pkg::REPORT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_report_start,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_payload_byte,
  input  logic       out_has_byte,
  input  logic       out_last,
  input  logic [3:0] out_status,
  input  logic [5:0] out_payload_count,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import hrd_pkg::*;

  typedef struct {
    logic [7:0] pbyte;
    logic       has_byte;
    logic       last;
    status_t    status;
    logic [5:0] count;
  } deframe_result_t;

  deframe_result_t due_responses[$];

  logic [7:0] resp_cmd;
  logic [5:0] capacity;
  logic [6:0] pos;
  logic [7:0] flen;
  logic [7:0] csum;
  status_t    first_err;
  logic       frame_closed;
  logic [7:0] payload_mem [STORE_DEPTH];

  task automatic close_with(input status_t code);
    deframe_result_t r;
    frame_closed = 1'b1;
    r.pbyte    = 8'd0;
    r.has_byte = 1'b0;
    r.last     = 1'b1;
    r.status   = code;
    r.count    = 6'd0;
    due_responses.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic start);
    logic [6:0]      p;
    logic [7:0]      want_cmd;
    int              cap;
    int              count;
    deframe_result_t r;
    if (start) begin
      pos          = '0;
      flen         = '0;
      csum         = '0;
      first_err    = ST_OK;
      frame_closed = 1'b0;
    end else if (frame_closed) begin
      return;
    end
    p        = pos;
    pos      = p + 7'd1;
    want_cmd = resp_cmd + 8'd1;
    if (p == 7'd0) begin
      if (b != REPORT_ID) close_with(ST_ID);
      return;
    end
    if (p == 7'd1) begin
      csum = csum + b;
      if (b != FRAME_TYPE) close_with(ST_TYPE);
      return;
    end
    if (p == 7'd2) begin
      csum = csum + b;
      flen = b;
      if (b < MIN_LEN || int'(b) >= REPORT_BYTES) close_with(ST_LEN);
      return;
    end
    if (p == 7'd5 && b != DIR_BYTE && first_err == ST_OK) first_err = ST_DIR;
    if (p == 7'd6 && b != want_cmd && first_err == ST_OK) first_err = ST_CMD;
    if (int'(p) + 2 <= int'(flen)) begin
      csum = csum + b;
      if (p >= 7'd7) payload_mem[p - 7'd7] = b;
      return;
    end
    if (int'(p) + 1 == int'(flen)) begin
      if ((csum ^ CHK_INVERT) != b) first_err = ST_CHECKSUM;
      return;
    end
    // end marker position
    if (first_err == ST_CHECKSUM) begin
      close_with(ST_CHECKSUM);
    end else if (b != END_MARKER) begin
      close_with(ST_END);
    end else if (first_err != ST_OK) begin
      close_with(first_err);
    end else begin
      cap = (int'(capacity) > CAPACITY_LIMIT) ? CAPACITY_LIMIT : int'(capacity);
      if (flen < HDR_TRAILER || int'(flen) - int'(HDR_TRAILER) > cap) begin
        close_with(ST_SIZE);
      end else begin
        frame_closed = 1'b1;
        count = int'(flen) - int'(HDR_TRAILER);
        if (count == 0) begin
          r.pbyte    = 8'd0;
          r.has_byte = 1'b0;
          r.last     = 1'b1;
          r.status   = ST_OK;
          r.count    = 6'd0;
          due_responses.push_back(r);
        end else begin
          for (int i = 0; i < count; i++) begin
            r.pbyte    = payload_mem[i];
            r.has_byte = 1'b1;
            r.last     = (i == count - 1);
            r.status   = ST_OK;
            r.count    = 6'(count);
            due_responses.push_back(r);
          end
        end
      end
    end
  endtask

  task automatic check_result();
    deframe_result_t r;
    if (due_responses.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected result: byte %02h has %0b last %0b status %0d count %0d",
                 $time, out_payload_byte, out_has_byte, out_last, out_status,
                 out_payload_count);
      return;
    end
    r = due_responses.pop_front();
    if (out_payload_byte !== r.pbyte || out_has_byte !== r.has_byte ||
        out_last !== r.last || out_status !== r.status ||
        out_payload_count !== r.count) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t result mismatch: expected byte %02h has %0b last %0b status %0d ",
                  "count %0d, got byte %02h has %0b last %0b status %0d count %0d"},
                 $time, r.pbyte, r.has_byte, r.last, r.status, r.count,
                 out_payload_byte, out_has_byte, out_last, out_status, out_payload_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      resp_cmd     = 8'd0;
      capacity     = 6'd56;
      pos          = '0;
      flen         = '0;
      csum         = '0;
      first_err    = ST_OK;
      frame_closed = 1'b1;
      mismatches   = 0;
      due_responses.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LAST_CMD:    resp_cmd = cfg_data;
          CFG_MAX_PAYLOAD: capacity = cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) deframe_byte(in_rx_byte, in_report_start);
    end
    pending = due_responses.size();
  end

endmodule

/* tb/tb_hid_response_deframer_top.sv */
// ----------------------------------------------------------------------------
// tb_hid_response_deframer_top
// directed and random report streams into the deframer with bursty input and
// patterned output stalls; a side checker predicts and compares the results
// ----------------------------------------------------------------------------
module tb_hid_response_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrd_pkg::*;

  localparam int REPORT_BYTES = REPORT_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 16;
  localparam int PHASES       = 4;
  localparam int SETTLE       = 16;

  localparam int unsigned BAD_ID   = 1 << 0;
  localparam int unsigned BAD_TYPE = 1 << 1;
  localparam int unsigned BAD_SUM  = 1 << 2;
  localparam int unsigned BAD_END  = 1 << 3;
  localparam int unsigned BAD_DIR  = 1 << 4;
  localparam int unsigned BAD_CMD  = 1 << 5;
  localparam int          FAULT_KINDS = 6;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte      = 8'd0;
  logic       in_report_start = 1'b0;
  logic       out_valid;
  logic       out_stall       = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_has_byte;
  logic       out_last;
  logic [3:0] out_status;
  logic [5:0] out_payload_count;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index       = CFG_LAST_CMD;
  logic [7:0] cfg_data        = 8'd0;

  int         mismatches;
  int         pending;
  int         cycles     = 0;
  int         burst_left = 0;
  int         stall_run  = 0;
  int         stall_mode = 0;
  logic [7:0] cur_cmd    = 8'd0;

  always #1 clk = ~clk;

  hid_response_deframer_top #(
    .REPORT_BYTES(REPORT_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_report_start  (in_report_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_payload_count(out_payload_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hid_response_deframer_checker #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_deframe_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_report_start  (in_report_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_payload_count(out_payload_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("hid_response_deframer_top verification failed");
      $finish;
    end
  end

  // receiver stall pattern in one of four randomly chosen modes
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_run % 5 < 2);
    endcase
  end

  task automatic put_byte(input logic [7:0] b, input logic start);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid        = 1'b1;
    in_rx_byte      = b;
    in_report_start = start;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_LAST_CMD) cur_cmd = data;
  endtask

  function automatic logic [7:0] nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic run_report(input int len, input int unsigned faults, input int n_send);
    logic [7:0] rpt [REPORT_BYTES];
    logic [7:0] sum;
    for (int i = 0; i < REPORT_BYTES; i++) rpt[i] = 8'($urandom);
    rpt[0] = REPORT_ID;
    rpt[1] = FRAME_TYPE;
    rpt[2] = 8'(len);
    rpt[5] = DIR_BYTE;
    rpt[6] = cur_cmd + 8'd1;
    if (faults & BAD_DIR) rpt[5] ^= nonzero();
    if (faults & BAD_CMD) rpt[6] ^= nonzero();
    if (len >= int'(MIN_LEN) && len < REPORT_BYTES) begin
      sum = '0;
      for (int i = 1; i <= len - 2; i++) sum += rpt[i];
      rpt[len - 1] = sum ^ CHK_INVERT;
      rpt[len]     = END_MARKER;
      if (faults & BAD_SUM) rpt[len - 1] ^= nonzero();
      if (faults & BAD_END) rpt[len] ^= nonzero();
    end
    if (faults & BAD_TYPE) rpt[1] ^= nonzero();
    if (faults & BAD_ID) rpt[0] ^= nonzero();
    for (int i = 0; i < n_send && i < REPORT_BYTES; i++) put_byte(rpt[i], i == 0);
  endtask

  initial begin
    int          counted;
    int          len;
    int          n_send;
    int          pick;
    int unsigned faults;
    logic [7:0]  cap_pick;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // bytes with no report open are dropped
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);

    write_reg(CFG_LAST_CMD, 8'hFF);
    write_reg(CFG_MAX_PAYLOAD, 8'd56);
    run_report(8, 0, 9);
    run_report(8, BAD_ID, 1);
    run_report(8, BAD_TYPE, 2);
    run_report(5, 0, 3);
    run_report(65, 0, 3);
    run_report(255, 0, 3);
    run_report(0, 0, 3);
    run_report(9, BAD_SUM, 10);
    run_report(9, BAD_END, 10);
    run_report(10, BAD_DIR, 11);
    run_report(10, BAD_CMD, 11);
    run_report(10, BAD_DIR | BAD_END, 11);
    run_report(10, BAD_SUM | BAD_CMD, 11);
    run_report(6, 0, 7);
    run_report(7, 0, 12);
    run_report(20, 0, 12);
    run_report(12, 0, 13);
    run_report(64, 0, REPORT_BYTES);
    write_reg(CFG_MAX_PAYLOAD, 8'd0);
    run_report(9, 0, 10);
    run_report(8, 0, 9);
    write_reg(CFG_MAX_PAYLOAD, 8'd63);
    run_report(64, 0, REPORT_BYTES);
    write_reg(CFG_LAST_CMD, 8'h00);
    run_report(10, 0, 11);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap_pick = 8'd56;
        1:       cap_pick = 8'd12;
        2:       cap_pick = 8'd63;
        default: cap_pick = 8'($urandom_range(0, 63));
      endcase
      write_reg(CFG_LAST_CMD, 8'($urandom));
      write_reg(CFG_MAX_PAYLOAD, cap_pick);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
        faults = 0;
        if ($urandom_range(0, 99) < 45)
          repeat ($urandom_range(1, 2)) faults |= 1 << $urandom_range(0, FAULT_KINDS - 1);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          len     = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(65, 255);
          n_send  = $urandom_range(3, 8);
        end else begin
          len  = (pick < 70) ? $urandom_range(6, 20) : $urandom_range(6, 64);
          pick = $urandom_range(0, 99);
          if (pick < 15) n_send = $urandom_range(1, len);
          else if (pick < 35) n_send = REPORT_BYTES;
          else n_send = len + 1 + $urandom_range(0, 3);
          if (n_send > REPORT_BYTES) n_send = REPORT_BYTES;
        end
        counted += n_send;
        run_report(len, faults, n_send);
      end
      // leave no report open before the next register change
      len = $urandom_range(8, 12);
      run_report(len, 0, len + 1);
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("hid_response_deframer_top verification clean");
    else
      $display("hid_response_deframer_top verification failed");
    $finish;
  end

endmodule
